// ----- rtl/robin_hood_hash_insert_top_defines.svh -----
// assertion macros shared by the insert block
`ifndef ROBIN_HOOD_HASH_INSERT_TOP_DEFINES_SVH
`define ROBIN_HOOD_HASH_INSERT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RHH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RHH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define RHH_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RHH_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/rhh_pkg.sv -----
package rhh_pkg;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_OPEN,
      ST_PROBE,
      ST_FIN
   } rhh_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic clr_step;
      logic load_key;
      logic mod_step;
      logic start_probe;
      logic probe;
      logic publish;
   } rhh_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clr_last;
      logic mod_last;
      logic slot_empty;
      logic last_probe;
   } rhh_sts_type;

   // fixed widths of the result fields
   localparam int SLOT_OUT_BITS  = 4;
   localparam int DIST_OUT_BITS  = 4;
   localparam int PROBE_OUT_BITS = 5;

endpackage

// ----- rtl/robin_hood_hash_insert_top.sv -----
// Robin Hood hash insert: each request carries one key, which is placed in an
// open-addressed table of TABLE_SLOTS slots by linear probing from slot
// key mod TABLE_SLOTS, swapping with any resident nearer its home; one result
// per request gives status, final slot, probe length, probes used and, when
// the table is full, the key dropped. After reset a clearing pass empties
// the table slot by slot, with req_stall high. An insert then runs from
// acceptance to the next acceptance through these steps: the accepting
// cycle, which also sums the residues of the key bits, $clog2(KEY_BITS + 1)
// compare and subtract steps that bring that sum down to the home slot, the
// home slot read, one slot per cycle through the table RAM (one read and one
// write port), and the load of the result register, which waits while an
// earlier result is still held there by rsp_stall. One request is in progress
// at a time; a finished result may wait in its register while the next
// request is accepted.
module robin_hood_hash_insert_top #(
   parameter int TABLE_SLOTS = 16,
   parameter int KEY_BITS    = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KEY_BITS-1:0] req_new_key,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_status,
   output logic [3:0]          rsp_final_slot,
   output logic [3:0]          rsp_final_probe_length,
   output logic [4:0]          rsp_probes_used,
   output logic [KEY_BITS-1:0] rsp_dropped_key
);

   import rhh_pkg::*;

   rhh_cmd_type cmd;
   rhh_sts_type sts;

   // sequencing
   rhh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // table, probe registers and result register
   rhh_dp #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KEY_BITS    (KEY_BITS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_new_key            (req_new_key),
      .rsp_status             (rsp_status),
      .rsp_final_slot         (rsp_final_slot),
      .rsp_final_probe_length (rsp_final_probe_length),
      .rsp_probes_used        (rsp_probes_used),
      .rsp_dropped_key        (rsp_dropped_key)
   );

endmodule

// ----- rtl/rhh_ram.sv -----
module rhh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rhh_dp.sv -----
module rhh_dp #(
   parameter int TABLE_SLOTS = 16,
   parameter int KEY_BITS    = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rhh_pkg::rhh_cmd_type  cmd,
   output rhh_pkg::rhh_sts_type  sts,
   input  logic [KEY_BITS-1:0]   req_new_key,
   output logic                  rsp_status,
   output logic [3:0]            rsp_final_slot,
   output logic [3:0]            rsp_final_probe_length,
   output logic [4:0]            rsp_probes_used,
   output logic [KEY_BITS-1:0]   rsp_dropped_key
);

   import rhh_pkg::*;

   localparam int SW = $clog2(TABLE_SLOTS);
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam int QW = $clog2(KEY_BITS + 1);
   localparam int MW = $clog2(QW + 1);
   localparam int AW = SW + QW;
   localparam int RW = 1 + KEY_BITS + SW;

   // residue of each key bit weight modulo the table size
   function automatic logic [KEY_BITS-1:0][SW-1:0] residue_lut();
      logic [KEY_BITS-1:0][SW-1:0] wt;
      int                          w;
      w = 1;
      for (int i = 0; i < KEY_BITS; i++) begin
         wt[i] = SW'(w);
         w     = 2 * w;
         if (w >= TABLE_SLOTS) begin
            w = w - TABLE_SLOTS;
         end
      end
      return wt;
   endfunction

   localparam logic [KEY_BITS-1:0][SW-1:0] BIT_RESIDUE = residue_lut();

   localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);
   localparam logic [CW-1:0] LAST_CNT  = CW'(TABLE_SLOTS - 1);
   localparam logic [MW-1:0] LAST_STEP = MW'(QW - 1);
   localparam logic [AW-1:0] DIV_TOP   = AW'(TABLE_SLOTS) << (QW - 1);

   // working registers
   logic [KEY_BITS-1:0] held_ff, held_in;
   logic [AW-1:0]       rem_ff, rem_in;
   logic [AW-1:0]       div_ff, div_in;
   logic [MW-1:0]       mcnt_ff, mcnt_in;
   logic [SW-1:0]       pos_ff, pos_in;
   logic [SW-1:0]       dist_ff, dist_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                full_ff, full_in;

   // result registers
   logic                out_status_ff;
   logic [3:0]          out_slot_ff;
   logic [3:0]          out_dist_ff;
   logic [4:0]          out_probes_ff;
   logic [KEY_BITS-1:0] out_key_ff;

   // table port
   logic                ram_we;
   logic [SW-1:0]       ram_raddr;
   logic [RW-1:0]       ram_wdata;
   logic [RW-1:0]       ram_rdata;
   logic                rd_occ;
   logic [KEY_BITS-1:0] rd_key;
   logic [SW-1:0]       rd_dist;

   logic [SW-1:0]       pos_next;
   logic [AW-1:0]       key_sum;
   logic                swap;
   logic [SW+3:0]       slot_ext;
   logic [SW+3:0]       dist_ext;
   logic [CW+4:0]       cnt_ext;

   rhh_ram #(
      .WIDTH (RW),
      .DEPTH (TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // unpack the slot read back
   assign rd_occ  = ram_rdata[RW-1];
   assign rd_key  = ram_rdata[RW-2:SW];
   assign rd_dist = ram_rdata[SW-1:0];

   // next slot with wrap
   assign pos_next = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;

   // sum of bit residues, congruent to the key modulo the table size
   always_comb begin
      key_sum = '0;
      for (int i = 0; i < KEY_BITS; i++) begin
         if (req_new_key[i]) begin
            key_sum = key_sum + AW'(BIT_RESIDUE[i]);
         end
      end
   end

   // resident is closer to home than the carried key
   assign swap = rd_occ && (dist_ff > rd_dist);

   // table access
   always_comb begin
      ram_raddr = cmd.start_probe ? rem_ff[SW-1:0] : pos_next;
      ram_we    = cmd.clr_step || (cmd.probe && (!rd_occ || swap));
      ram_wdata = cmd.clr_step ? '0 : {1'b1, held_ff, dist_ff};
   end

   // working register updates
   always_comb begin
      held_in = held_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      mcnt_in = mcnt_ff;
      pos_in  = pos_ff;
      dist_in = dist_ff;
      cnt_in  = cnt_ff;
      full_in = full_ff;
      if (cmd.clr_step) begin
         pos_in = pos_next;
      end
      if (cmd.load_key) begin
         held_in = req_new_key;
         rem_in  = key_sum;
         div_in  = DIV_TOP;
         mcnt_in = '0;
      end
      // compare and subtract against shrinking multiples of the table size
      if (cmd.mod_step) begin
         if (rem_ff >= div_ff) begin
            rem_in = rem_ff - div_ff;
         end
         div_in  = div_ff >> 1;
         mcnt_in = mcnt_ff + 1'b1;
      end
      if (cmd.start_probe) begin
         pos_in  = rem_ff[SW-1:0];
         dist_in = '0;
         cnt_in  = '0;
      end
      if (cmd.probe) begin
         cnt_in  = cnt_ff + 1'b1;
         full_in = rd_occ;
         if (rd_occ) begin
            pos_in  = pos_next;
            dist_in = (swap ? rd_dist : dist_ff) + 1'b1;
            if (swap) begin
               held_in = rd_key;
            end
         end
      end
   end

   // slot pointer doubles as the clearing counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      mcnt_ff <= mcnt_in;
      dist_ff <= dist_in;
      cnt_ff  <= cnt_in;
      full_ff <= full_in;
   end

   // result fields at their fixed widths
   assign slot_ext = {4'b0, pos_ff};
   assign dist_ext = {4'b0, dist_ff};
   assign cnt_ext  = {5'b0, cnt_ff};

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_status_ff <= full_ff;
         out_slot_ff   <= full_ff ? '0 : slot_ext[3:0];
         out_dist_ff   <= full_ff ? '0 : dist_ext[3:0];
         out_probes_ff <= cnt_ext[4:0];
         out_key_ff    <= full_ff ? held_ff : '0;
      end
   end

   // status to the controller
   always_comb begin
      sts.clr_last   = (pos_ff == LAST_SLOT);
      sts.mod_last   = (mcnt_ff == LAST_STEP);
      sts.slot_empty = !rd_occ;
      sts.last_probe = (cnt_ff == LAST_CNT);
   end

   assign rsp_status             = out_status_ff;
   assign rsp_final_slot         = out_slot_ff;
   assign rsp_final_probe_length = out_dist_ff;
   assign rsp_probes_used        = out_probes_ff;
   assign rsp_dropped_key        = out_key_ff;

endmodule

// ----- rtl/rhh_ctrl.sv -----
`include "robin_hood_hash_insert_top_defines.svh"

module rhh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rhh_pkg::rhh_cmd_type cmd,
   input  rhh_pkg::rhh_sts_type sts
);

   import rhh_pkg::*;

   rhh_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // result register can take a new result
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_MOD;
         end
         ST_MOD: begin
            if (sts.mod_last) state_in = ST_OPEN;
         end
         ST_OPEN: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (sts.slot_empty || sts.last_probe) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_step    = 1'b1;
         ST_IDLE:  cmd.load_key    = req_valid;
         ST_MOD:   cmd.mod_step    = 1'b1;
         ST_OPEN:  cmd.start_probe = 1'b1;
         ST_PROBE: cmd.probe       = 1'b1;
         ST_FIN:   cmd.publish     = out_free;
         default:  cmd             = '0;
      endcase
   end

   // result valid flag
   assign rsp_valid_in = cmd.publish ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `RHH_ASSERT_NXT(a_probe_ends, clock, reset, (state_ff == ST_PROBE) && (sts.slot_empty || sts.last_probe), state_ff == ST_FIN, "probe walk did not end on empty slot or last probe")
   `RHH_ASSERT_NXT(a_fin_publish, clock, reset, (state_ff == ST_FIN) && !rsp_valid_ff, rsp_valid_ff && (state_ff == ST_IDLE), "free result register not loaded")
   `RHH_ASSERT_NXT(a_mod_to_open, clock, reset, (state_ff == ST_MOD) && sts.mod_last, state_ff == ST_OPEN, "remainder done but no home read")
   `RHH_ASSERT_IMP(a_clear_quiet, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff, "result shown during clearing pass")

endmodule
